// ===== rtl/nnt_pkg.sv =====
// Shared types and constants for the nearest-neighbor tour block.
// Holds the fixed channel field widths and the controller/datapath command
// and status structs. No dependencies.
package nnt_pkg;

  localparam int DIST_W  = 24;  // distance field of an input beat
  localparam int POS_W   = 6;   // tour_position field of a result beat
  localparam int NODE_W  = 6;   // node_index field of a result beat
  localparam int COUNT_W = 7;   // node_count configuration register

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;    // input channel may take a beat
    logic build_init;  // last matrix entry is being taken: start a new tour
    logic scan_step;   // issue one candidate read of the current row
    logic emit;        // place the chosen node and load the result register
  } nnt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_fire;    // an input beat is accepted this cycle
    logic load_last;  // the entry being loaded completes the matrix
    logic scan_last;  // the candidate being issued is the last of the row
    logic last_pos;   // the next emitted position is the final one
    logic out_free;   // the result register can take a new beat
  } nnt_status_t;

endpackage

// ===== rtl/nnt_if.sv =====
// Handshake interfaces for the nearest-neighbor tour block: input matrix
// entries, tour results and the node count configuration write.
// Depends on nnt_pkg for the field widths.
interface nnt_in_if import nnt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;

  modport source (output valid, output distance, input ready);
  modport sink (input valid, input distance, output ready);
endinterface

interface nnt_out_if import nnt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  tour_position;
  logic [NODE_W-1:0] node_index;
  logic              last;

  modport source (output valid, output tour_position, output node_index, output last,
                  input ready);
  modport sink (input valid, input tour_position, input node_index, input last,
                output ready);
endinterface

interface nnt_cfg_if import nnt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] node_count;

  modport source (output valid, output node_count, input ready);
  modport sink (input valid, input node_count, output ready);
endinterface

// ===== rtl/nnt_datapath.sv =====
// Datapath of the nearest-neighbor tour block: distance memory, load
// counters, visited flags, candidate scan with running minimum, result register.
// Depends on nnt_pkg and the channel interfaces in nnt_if.
module nnt_datapath import nnt_pkg::*; #(
  parameter int MAX_NODES = 64,
  parameter int DIST_BITS = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  nnt_in_if.sink        in_if,
  nnt_out_if.source     out_if,
  nnt_cfg_if.sink       cfg_if,
  input  nnt_cmd_t      cmd,
  output nnt_status_t   sts
);

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int PCNT_W = IDX_W + 1;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 1 << ADDR_W;

  // Distance memory, row-major with a row stride of the full node range.
  logic [DIST_BITS-1:0] mem [DEPTH];
  logic [DIST_BITS-1:0] rd_data_r;

  logic [COUNT_W-1:0]   node_count_r;
  logic [COUNT_W-1:0]   n_last_full;
  logic [IDX_W-1:0]     n_last;

  logic [IDX_W-1:0]     row_r, col_r;
  logic [IDX_W-1:0]     cur_r;
  logic [IDX_W-1:0]     scan_i_r;
  logic [PCNT_W-1:0]    pos_r;
  logic [MAX_NODES-1:0] visited_r;

  logic                 cand_ok_r;
  logic [IDX_W-1:0]     cand_idx_r;
  logic                 have_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [DIST_BITS-1:0] best_d_r;

  logic                 out_valid_r;
  logic [POS_W-1:0]     out_pos_r;
  logic [NODE_W-1:0]    out_node_r;
  logic                 out_last_r;

  logic                 in_fire;
  logic                 cfg_fire;
  logic                 load_last;
  logic [IDX_W-1:0]     node_sel;
  logic                 take_cand;

  // Node count clamped to 1..MAX_NODES, kept as the index of the last node.
  always_comb begin
    if (node_count_r == '0) begin
      n_last_full = '0;
    end else if (node_count_r > COUNT_W'(MAX_NODES)) begin
      n_last_full = COUNT_W'(MAX_NODES - 1);
    end else begin
      n_last_full = node_count_r - COUNT_W'(1);
    end
  end
  assign n_last = n_last_full[IDX_W-1:0];

  assign in_fire   = in_if.valid & cmd.in_ready;
  assign cfg_fire  = cfg_if.valid;
  assign load_last = (row_r == n_last) && (col_r == n_last);
  assign node_sel  = (pos_r == '0) ? '0 : best_idx_r;
  assign take_cand = cand_ok_r && (!have_r || (rd_data_r < best_d_r));

  assign in_if.ready  = cmd.in_ready;
  assign cfg_if.ready = 1'b1;

  assign sts.in_fire   = in_fire;
  assign sts.load_last = load_last;
  assign sts.scan_last = (scan_i_r == n_last);
  assign sts.last_pos  = (pos_r == PCNT_W'(n_last));
  assign sts.out_free  = !out_valid_r || out_if.ready;

  assign out_if.valid         = out_valid_r;
  assign out_if.tour_position = out_pos_r;
  assign out_if.node_index    = out_node_r;
  assign out_if.last          = out_last_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem[{row_r, col_r}] <= DIST_BITS'(in_if.distance);
    end
    rd_data_r <= mem[{cur_r, scan_i_r}];
  end

  // Configuration register and load counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= COUNT_W'(MAX_NODES);
      row_r        <= '0;
      col_r        <= '0;
    end else if (cfg_fire) begin
      node_count_r <= cfg_if.node_count;
      row_r        <= '0;
      col_r        <= '0;
    end else if (in_fire) begin
      if (col_r == n_last) begin
        col_r <= '0;
        row_r <= load_last ? '0 : row_r + IDX_W'(1);
      end else begin
        col_r <= col_r + IDX_W'(1);
      end
    end
  end

  // Tour state: visited flags, position count, scan index, running minimum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
      pos_r     <= '0;
      scan_i_r  <= '0;
      have_r    <= 1'b0;
      cand_ok_r <= 1'b0;
    end else begin
      cand_ok_r <= cmd.scan_step && !visited_r[scan_i_r];
      if (cmd.build_init) begin
        visited_r    <= MAX_NODES'(1);
        pos_r        <= '0;
        scan_i_r     <= '0;
        have_r       <= 1'b0;
      end else if (cmd.emit) begin
        visited_r[node_sel] <= 1'b1;
        pos_r               <= pos_r + PCNT_W'(1);
        scan_i_r            <= '0;
        have_r              <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          scan_i_r <= scan_i_r + IDX_W'(1);
        end
        if (take_cand) begin
          have_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cand_idx_r <= scan_i_r;
    if (take_cand) begin
      best_idx_r <= cand_idx_r;
      best_d_r   <= rd_data_r;
    end
    if (cmd.build_init) begin
      cur_r <= '0;
    end else if (cmd.emit) begin
      cur_r <= node_sel;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pos_r  <= POS_W'(pos_r);
      out_node_r <= NODE_W'(node_sel);
      out_last_r <= sts.last_pos;
    end
  end

  // Every emitted position has marked exactly one node as visited.
  a_visited_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.emit) |-> ($countones(visited_r) == int'(pos_r)))
    else $error("visited flag count does not match emitted positions");

  // A node chosen by the scan was never visited before.
  a_pick_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && (pos_r != '0)) |-> (have_r && !visited_r[best_idx_r]))
    else $error("emitted node has no candidate or was already visited");

  // The scan never reads past the last node of the row.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> (scan_i_r <= n_last))
    else $error("candidate scan beyond node count");

  // A result is only loaded when the result register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result register overwritten while full");

endmodule

// ===== rtl/nnt_ctrl.sv =====
// Controller of the nearest-neighbor tour block: sequences matrix load,
// row scans and result emission through command and status structs.
// Depends on nnt_pkg.
module nnt_ctrl import nnt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  nnt_status_t sts,
  output nnt_cmd_t    cmd
);

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        cmd.in_ready   = 1'b1;
        cmd.build_init = sts.in_fire && sts.load_last;
        if (sts.in_fire && sts.load_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last candidate's read data is compared in this cycle.
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.last_pos ? S_LOAD : S_SCAN;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A scan is always followed by the drain cycle, then an emit attempt.
  a_drain_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |=> (state_r == S_EMIT))
    else $error("drain cycle not followed by emit");

  // Input beats are only taken while no tour is being built.
  a_no_load_in_build: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step || cmd.emit) |-> !cmd.in_ready)
    else $error("input taken during tour build");

  // The final emission returns the controller to loading.
  a_last_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.last_pos) |=> (state_r == S_LOAD))
    else $error("controller did not return to load after last position");

endmodule

// ===== rtl/nearest_neighbor_tour.sv =====
// Top level of the nearest-neighbor tour block: a controller and a datapath.
// Depends on nnt_pkg, the interfaces in nnt_if, nnt_ctrl and nnt_datapath.
//
// Usage: write node_count (1..MAX_NODES; 0 acts as 1, larger values as
// MAX_NODES) on the cfg channel while the block is idle; each write also
// restarts the matrix load at row 0, column 0. Then send node_count squared
// distance beats on the in channel in row-major order (row = from-node).
// Entries load at one beat per cycle into a distance memory.
// The beat that completes the matrix starts a greedy tour from node 0. Each
// later position takes the closest unvisited node from the current node, the
// lowest index winning on a tie. One out beat is produced per tour position,
// with last set on the final one.
// The first out beat (position 0) passes through the emit state and the result
// register after the final input beat. Each further position needs a scan of
// the current memory row, one read per cycle, then a drain state and an emit
// state. The single memory read port sets the pace of the scan.
// The in channel is held not ready for the whole build. If the receiver
// stalls, the result register holds its beat and the build waits before
// placing the next position; nothing is dropped. Reset clears the load
// counters, visited flags and result valid, and sets node_count to
// MAX_NODES; the distance memory is not cleared and needs no clearing pass.
module nearest_neighbor_tour import nnt_pkg::*; #(
  parameter int MAX_NODES = 64,
  parameter int DIST_BITS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  nnt_in_if.sink    in_if,
  nnt_out_if.source out_if,
  nnt_cfg_if.sink   cfg_if
);

  nnt_cmd_t    cmd;
  nnt_status_t sts;

  nnt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  nnt_datapath #(
    .MAX_NODES (MAX_NODES),
    .DIST_BITS (DIST_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the nearest-neighbor tour block.
// Depends on nnt_pkg, the channel interfaces in nnt_if and nearest_neighbor_tour.
// Loads matrices, predicts each greedy tour and checks every result beat.
module testbench;
  import nnt_pkg::*;

  localparam int MAX_NODES     = 64;
  localparam int SETTLE_CYCLES = 4;                   // quiet time before a node_count write
  localparam int DRAIN_CYCLES  = 2 * MAX_NODES + 10;  // quiet time at the end, longer than a scan of the widest row
  localparam int IDLE_LIMIT    = 5000;                // cycles without any beat before giving up
  localparam int RANDOM_BEATS  = 110;                 // per idling phase
  localparam int PARTIAL_BEATS = 40;                  // entries sent under an oversized count

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;
  typedef enum logic [1:0] {SHAPE_WIDE, SHAPE_NARROW, SHAPE_MAX, SHAPE_MIXED} dist_shape_t;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [NODE_W-1:0] node;
    logic              last;
  } tour_beat_t;

  // One step of the directed plan. A nonzero tour_len gives the tour typed in by hand;
  // it belongs on the beat that completes a matrix.
  typedef struct packed {
    row_kind_t                kind;
    logic [DIST_W-1:0]        value;
    logic [2:0]               tour_len;
    logic [0:3][NODE_W-1:0]   tour;
  } plan_row_t;

  localparam logic [0:3][NODE_W-1:0] NO_TOUR = '0;
  localparam int PLAN_ROWS = 22;

  plan_row_t directed_plan [PLAN_ROWS] = '{
    // A single node, written directly and as zero; the only entry yields the whole tour.
    '{ROW_CFG,  24'd1,      3'd0, NO_TOUR},
    '{ROW_BEAT, 24'h000000, 3'd1, '{6'd0, 6'd0, 6'd0, 6'd0}},
    '{ROW_CFG,  24'd0,      3'd0, NO_TOUR},
    '{ROW_BEAT, DIST_MAX,   3'd1, '{6'd0, 6'd0, 6'd0, 6'd0}},
    // Two nodes: a load abandoned after two entries, then restarted by a second write.
    '{ROW_CFG,  24'd2,      3'd0, NO_TOUR},
    '{ROW_BEAT, 24'h123456, 3'd0, NO_TOUR},
    '{ROW_BEAT, 24'hABCDEF, 3'd0, NO_TOUR},
    '{ROW_CFG,  24'd2,      3'd0, NO_TOUR},
    '{ROW_BEAT, 24'h000001, 3'd0, NO_TOUR},
    '{ROW_BEAT, 24'h800000, 3'd0, NO_TOUR},
    '{ROW_BEAT, 24'h7FFFFF, 3'd0, NO_TOUR},
    '{ROW_BEAT, 24'h000000, 3'd2, '{6'd0, 6'd1, 6'd0, 6'd0}},
    // Three nodes, every distance at the maximum: the first step is a tie, lowest index wins.
    '{ROW_CFG,  24'd3,      3'd0, NO_TOUR},
    '{ROW_BEAT, DIST_MAX,   3'd0, NO_TOUR},
    '{ROW_BEAT, DIST_MAX,   3'd0, NO_TOUR},
    '{ROW_BEAT, DIST_MAX,   3'd0, NO_TOUR},
    '{ROW_BEAT, DIST_MAX,   3'd0, NO_TOUR},
    '{ROW_BEAT, DIST_MAX,   3'd0, NO_TOUR},
    '{ROW_BEAT, DIST_MAX,   3'd0, NO_TOUR},
    '{ROW_BEAT, DIST_MAX,   3'd0, NO_TOUR},
    '{ROW_BEAT, DIST_MAX,   3'd0, NO_TOUR},
    '{ROW_BEAT, DIST_MAX,   3'd3, '{6'd0, 6'd1, 6'd2, 6'd0}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  nnt_in_if  in_ch ();
  nnt_out_if out_ch ();
  nnt_cfg_if cfg_ch ();

  nearest_neighbor_tour #(
    .MAX_NODES(MAX_NODES),
    .DIST_BITS(DIST_W)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Predictor state: the register as written, the load position and the matrix.
  logic [COUNT_W-1:0] node_count_reg = COUNT_W'(MAX_NODES);
  int unsigned        load_idx = 0;
  logic [DIST_W-1:0]  dist_mem [MAX_NODES * MAX_NODES];
  logic [NODE_W-1:0]  greedy_tour [MAX_NODES];

  tour_beat_t tour_expect [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned result_beats = 0;
  int unsigned tours_seen = 0;
  int unsigned quiet_cycles = 0;

  function automatic int unsigned nodes_in_use();
    if (node_count_reg == 0) return 1;
    if (node_count_reg > MAX_NODES) return MAX_NODES;
    return int'(node_count_reg);
  endfunction

  // Stores one matrix entry. On the entry that completes the matrix it builds the
  // greedy tour into greedy_tour and returns its length; otherwise it returns 0.
  function automatic int unsigned load_entry(input logic [DIST_W-1:0] d);
    int unsigned n, total, here, best, k, i;
    logic [MAX_NODES-1:0] visited;
    logic [DIST_W-1:0] cand, best_d;
    bit have;
    n = nodes_in_use();
    total = n * n;
    if (load_idx >= total) load_idx = 0;
    dist_mem[load_idx] = d;
    if (load_idx + 1 < total) begin
      load_idx++;
      return 0;
    end
    load_idx = 0;
    visited = '0;
    visited[0] = 1'b1;
    here = 0;
    greedy_tour[0] = '0;
    for (k = 1; k < n; k++) begin
      have = 1'b0;
      best = 0;
      best_d = '0;
      for (i = 0; i < n; i++) begin
        if (!visited[i]) begin
          cand = dist_mem[here * n + i];
          // Strict compare keeps the lowest index on equal distances.
          if (!have || cand < best_d) begin
            have = 1'b1;
            best = i;
            best_d = cand;
          end
        end
      end
      visited[best] = 1'b1;
      here = best;
      greedy_tour[k] = NODE_W'(best);
    end
    return n;
  endfunction

  function automatic logic [DIST_W-1:0] pick_distance(input dist_shape_t shape);
    case (shape)
      SHAPE_WIDE:   return DIST_W'($urandom);
      SHAPE_NARROW: return DIST_W'($urandom_range(3));   // many ties
      SHAPE_MAX:    return DIST_MAX;
      default: begin
        case ($urandom_range(2))
          0:       return '0;
          1:       return DIST_MAX;
          default: return DIST_W'($urandom);
        endcase
      end
    endcase
  endfunction

  // Presents one distance beat, holds it until taken, then records what it implies.
  // Valid is only lowered while idling, before a register write or at the end of the
  // run, so back-to-back beats keep it high.
  task automatic send_distance(input logic [DIST_W-1:0] d, input int unsigned typed_len,
                               input logic [0:3][NODE_W-1:0] typed_tour);
    int unsigned built, count, k;
    tour_beat_t nb;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.distance <= d;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
    built = load_entry(d);
    count = (built != 0 && typed_len != 0) ? typed_len : built;
    for (k = 0; k < count; k++) begin
      nb.position = POS_W'(k);
      nb.node = (typed_len != 0) ? typed_tour[k % 4] : greedy_tour[k];
      nb.last = (k == count - 1);
      tour_expect.insert(tour_expect.size(), nb);
    end
  endtask

  // The register is only written once every expected result has come back.
  task automatic write_node_count(input logic [COUNT_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (tour_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.node_count <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    node_count_reg = value;
    load_idx = 0;
    cfg_writes++;
  endtask

  task automatic send_matrix(input int unsigned beats, input dist_shape_t shape);
    for (int e = 0; e < beats; e++) send_distance(pick_distance(shape), 0, NO_TOUR);
  endtask

  // Mostly complete matrices of small size with random content; some loads are
  // abandoned part way and restarted by the next register write.
  task automatic run_random_tours(input int unsigned beat_budget);
    int unsigned n, cut, stop_at;
    bit must_write;
    stop_at = beats_sent + beat_budget;
    must_write = 1'b1;
    while (beats_sent < stop_at) begin
      if (must_write || $urandom_range(3) != 0) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
        write_node_count((n == 1 && $urandom_range(1) == 1) ? '0 : COUNT_W'(n));
      end else begin
        n = nodes_in_use();
      end
      cut = n * n;
      if (n > 1 && $urandom_range(6) == 0) cut = $urandom_range(1, n * n - 1);
      send_matrix(cut, dist_shape_t'($urandom_range(3)));
      must_write = (cut != n * n);
    end
  endtask

  // Result side: compare every accepted beat against the oldest expectation, then
  // pick the ready level for the next cycle.
  always @(posedge clk) begin
    tour_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_beats++;
      if (out_ch.last) tours_seen++;
      if (tour_expect.size() == 0) begin
        $error("unexpected result beat: tour_position %0d node_index %0d last %0b",
               out_ch.tour_position, out_ch.node_index, out_ch.last);
        mismatches++;
      end else begin
        want = tour_expect.pop_front();
        if (out_ch.tour_position !== want.position) begin
          $error("tour_position: expected %0d, got %0d", want.position, out_ch.tour_position);
          mismatches++;
        end
        if (out_ch.node_index !== want.node) begin
          $error("node_index: expected %0d, got %0d", want.node, out_ch.node_index);
          mismatches++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_ch.last);
          mismatches++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("Timeout: no beat for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, tour_expect.size());
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.distance = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.node_count = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_CFG) begin
        write_node_count(directed_plan[r].value[COUNT_W-1:0]);
      end else begin
        send_distance(directed_plan[r].value, directed_plan[r].tour_len, directed_plan[r].tour);
      end
    end

    send_idle_pct = 26;
    recv_idle_pct = 88;
    run_random_tours(RANDOM_BEATS);

    send_idle_pct = 88;
    recv_idle_pct = 26;
    run_random_tours(RANDOM_BEATS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_tours(RANDOM_BEATS);

    // An oversized value acts as the widest matrix, so a short load must yield nothing.
    write_node_count('1);
    send_matrix(PARTIAL_BEATS, SHAPE_WIDE);

    in_ch.valid <= 1'b0;
    while (tour_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d distance beats and %0d node_count writes, node counts 0 to 127.",
             beats_sent, cfg_writes);
    $display("Checked %0d result beats over %0d complete tours.", result_beats, tours_seen);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
